[sv/rgb2yuv_pkg.sv]
// ----------------------------------------------------------------------------
// rgb2yuv_pkg - shared definitions for the RGB24 to YCbCr 4:2:0 converter
// Field widths, configuration register indexes, reset values, the chroma
// kind code and the BT.601 conversion coefficients.
// ----------------------------------------------------------------------------
package rgb2yuv_pkg;

	// Field widths.
	localparam int COMP_W     = 8;
	localparam int CFG_W      = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int KIND_W     = 2;

	// Default frame size limits.
	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int MAX_HEIGHT_DEF = 4096;

	// Register reset values.
	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	// What the chroma byte of a result carries.
	typedef enum logic [KIND_W-1:0] {
		KIND_NONE = 2'd0,
		KIND_U    = 2'd1,
		KIND_V    = 2'd2
	} chroma_kind_t;

	// Weighted sums are formed in this signed width.
	localparam int SUM_W = 18;
	typedef logic signed [SUM_W-1:0] sum_t;

	// BT.601 studio-range coefficients, scaled by 256.
	localparam sum_t Y_R = 18'sd66;
	localparam sum_t Y_G = 18'sd129;
	localparam sum_t Y_B = 18'sd25;
	localparam sum_t U_R = -18'sd38;
	localparam sum_t U_G = -18'sd74;
	localparam sum_t U_B = 18'sd112;
	localparam sum_t V_R = 18'sd112;
	localparam sum_t V_G = -18'sd94;
	localparam sum_t V_B = -18'sd18;
	localparam sum_t ROUND_BIAS = 18'sd128;

	localparam logic [COMP_W-1:0] LUMA_OFFSET   = 8'd16;
	localparam logic [COMP_W-1:0] CHROMA_OFFSET = 8'd128;

endpackage

[sv/rgb24_to_yuv420_converter_unit.sv]
// ----------------------------------------------------------------------------
// rgb24_to_yuv420_converter_unit - RGB24 pixel stream to YCbCr 4:2:0 samples
// Converts each raster-order pixel to BT.601 luma and, at even columns, one
// chroma sample (U on even rows, V on odd rows), flagging the frame's last
// pixel.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                          Contents
//  s_axis    in         tvalid tready tdata[23:0]        red, green, blue
//  m_axis    out        tvalid tready tdata[15:0] tuser  luma, chroma; kind
//                       tlast                            frame end
//  cfg       in         valid ready index data           frame_width, height
//
//  One pixel is accepted per clock; its result passes the input register,
//  then the result register after the constant multiplies.
//  Sustained rate is one pixel per cycle, limited only by m_axis_tready.
//  A stall on m_axis holds the result register and backs up into the input
//  register; s_axis_tready drops only when both registers are full.
//  Reset clears the pipeline, the counters and restores 640 by 480.
//  cfg_ready is always high; writes should be made while the block is idle.
//
module rgb24_to_yuv420_converter_unit #(
	parameter int MAX_WIDTH  = rgb2yuv_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rgb2yuv_pkg::MAX_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Pixel input.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
	// Sample output.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // luma [7:0], chroma [15:8]
	output logic [1:0]  m_axis_tuser,   // chroma_kind [1:0]
	output logic        m_axis_tlast,   // frame_end
	// Configuration writes.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rgb2yuv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rgb2yuv_pkg::CFG_W-1:0]      cfg_data
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int LW = (CW + 1 > rgb2yuv_pkg::CFG_W) ? CW + 1 : rgb2yuv_pkg::CFG_W;
	localparam int LH = (RW + 1 > rgb2yuv_pkg::CFG_W) ? RW + 1 : rgb2yuv_pkg::CFG_W;

	// Configuration registers.
	logic [rgb2yuv_pkg::CFG_W-1:0] frame_width_q;
	logic [rgb2yuv_pkg::CFG_W-1:0] frame_height_q;

	// Raster position counters.
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	// Input stage.
	logic                           valid_s1;
	logic [rgb2yuv_pkg::COMP_W-1:0] red_s1, green_s1, blue_s1;
	rgb2yuv_pkg::chroma_kind_t      kind_s1;
	logic                           last_s1;

	// Result stage.
	logic                           valid_s2;
	logic [rgb2yuv_pkg::COMP_W-1:0] luma_s2, chroma_s2;
	rgb2yuv_pkg::chroma_kind_t      kind_s2;
	logic                           last_s2;

	logic s_fire, adv_s2, adv_s1;
	logic [LW-1:0] w_ext, w_eff, w_last;
	logic [LH-1:0] h_ext, h_eff, h_last;
	logic row_end, frame_last;
	rgb2yuv_pkg::chroma_kind_t kind_next;

	// Handshake: the result register moves when empty or taken, the input
	// register moves when empty or when it can pass its item on.
	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = !valid_s1 || adv_s2;
	assign s_axis_tready = adv_s1;
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	// Clamp the configured frame size into its meaningful range.
	always_comb begin
		w_ext = LW'(frame_width_q);
		h_ext = LH'(frame_height_q);
		if (w_ext < LW'(2)) begin
			w_eff = LW'(2);
		end else if (w_ext > LW'(MAX_WIDTH)) begin
			w_eff = LW'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		if (h_ext < LH'(1)) begin
			h_eff = LH'(1);
		end else if (h_ext > LH'(MAX_HEIGHT)) begin
			h_eff = LH'(MAX_HEIGHT);
		end else begin
			h_eff = h_ext;
		end
		w_last = w_eff - LW'(1);
		h_last = h_eff - LH'(1);
	end

	// Row and frame end, and the chroma kind from the current position.
	assign row_end    = LW'(col_q) >= w_last;
	assign frame_last = row_end && (LH'(row_q) >= h_last);

	always_comb begin
		if (col_q[0]) begin
			kind_next = rgb2yuv_pkg::KIND_NONE;
		end else if (row_q[0]) begin
			kind_next = rgb2yuv_pkg::KIND_V;
		end else begin
			kind_next = rgb2yuv_pkg::KIND_U;
		end
	end

	// Configuration writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= rgb2yuv_pkg::FRAME_WIDTH_RST;
			frame_height_q <= rgb2yuv_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == rgb2yuv_pkg::REG_FRAME_WIDTH) begin
				frame_width_q <= cfg_data;
			end else if (cfg_index == rgb2yuv_pkg::REG_FRAME_HEIGHT) begin
				frame_height_q <= cfg_data;
			end
		end
	end

	// Position counters advance on every accepted pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (s_fire) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_last ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			red_s1   <= s_axis_tdata[7:0];
			green_s1 <= s_axis_tdata[15:8];
			blue_s1  <= s_axis_tdata[23:16];
			kind_s1  <= kind_next;
			last_s1  <= frame_last;
		end
	end

	// Weighted sums; the low byte of the floor shift is bits 15:8.
	rgb2yuv_pkg::sum_t r_x, g_x, b_x, y_sum, u_sum, v_sum;
	logic [rgb2yuv_pkg::COMP_W-1:0] luma_next, chroma_next;

	always_comb begin
		r_x = rgb2yuv_pkg::sum_t'({10'd0, red_s1});
		g_x = rgb2yuv_pkg::sum_t'({10'd0, green_s1});
		b_x = rgb2yuv_pkg::sum_t'({10'd0, blue_s1});
		y_sum = rgb2yuv_pkg::Y_R * r_x + rgb2yuv_pkg::Y_G * g_x
			+ rgb2yuv_pkg::Y_B * b_x + rgb2yuv_pkg::ROUND_BIAS;
		u_sum = rgb2yuv_pkg::U_R * r_x + rgb2yuv_pkg::U_G * g_x
			+ rgb2yuv_pkg::U_B * b_x + rgb2yuv_pkg::ROUND_BIAS;
		v_sum = rgb2yuv_pkg::V_R * r_x + rgb2yuv_pkg::V_G * g_x
			+ rgb2yuv_pkg::V_B * b_x + rgb2yuv_pkg::ROUND_BIAS;
		luma_next = y_sum[15:8] + rgb2yuv_pkg::LUMA_OFFSET;
		unique case (kind_s1)
			rgb2yuv_pkg::KIND_U: chroma_next = u_sum[15:8] + rgb2yuv_pkg::CHROMA_OFFSET;
			rgb2yuv_pkg::KIND_V: chroma_next = v_sum[15:8] + rgb2yuv_pkg::CHROMA_OFFSET;
			default:             chroma_next = '0;
		endcase
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			luma_s2   <= luma_next;
			chroma_s2 <= chroma_next;
			kind_s2   <= kind_s1;
			last_s2   <= last_s1;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {chroma_s2, luma_s2};
	assign m_axis_tuser  = kind_s2;
	assign m_axis_tlast  = last_s2;

	// A pixel without chroma carries a zero chroma byte.
	a_no_chroma_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == rgb2yuv_pkg::KIND_NONE)
			|-> m_axis_tdata[15:8] == 8'd0)
		else $error("chroma byte nonzero on a pixel without chroma");

	// The last pixel of a frame wraps both counters.
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && frame_last |=> (col_q == '0) && (row_q == '0))
		else $error("counters did not wrap after the frame's last pixel");

	// Input backpressure only when both stages hold an item and output stalls.
	a_ready_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && valid_s2 && !m_axis_tready)
		else $error("input stalled while the pipeline had room");

	// An accepted pixel lands in the input register.
	a_fill_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> valid_s1)
		else $error("accepted pixel lost from the input register");

endmodule

[verif/yuv420_sample_checker.sv]
// ----------------------------------------------------------------------------
// yuv420_sample_checker - scoreboard for the RGB24 to YCbCr 4:2:0 converter
// Watches the pixel, sample and register channels. It keeps its own copy of
// the frame size and the raster position, works out the luma, chroma and
// frame-end of each accepted pixel, and compares every accepted sample with
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module yuv420_sample_checker
	import rgb2yuv_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [23:0]          s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [15:0]          m_axis_tdata,   // luma [7:0], chroma [15:8]
	input  logic [1:0]           m_axis_tuser,   // chroma_kind [1:0]
	input  logic                 m_axis_tlast,   // frame_end
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   mismatch_count,
	output int                   samples_pending,
	output int                   frame_ends,
	output int                   u_samples,
	output int                   v_samples
);
	timeunit 1ns;
	timeprecision 1ps;

	// One output sample as the block should produce it.
	typedef struct packed {
		logic [COMP_W-1:0] luma;
		chroma_kind_t      kind;
		logic [COMP_W-1:0] chroma;
		logic              frame_end;
	} yuv_sample_t;

	yuv_sample_t      expected_samples[$];
	logic [CFG_W-1:0] width_reg;
	logic [CFG_W-1:0] height_reg;
	int               col_pos;
	int               row_pos;
	int               fails;
	int               frames_seen;
	int               u_seen;
	int               v_seen;
	int               sample_index;

	// Floor shift by 8 of a weighted sum, plus the offset, kept to 8 bits.
	function automatic logic [COMP_W-1:0] scale_down(input int sum, input int offset);
		return 8'((sum >>> 8) + offset);
	endfunction

	// Converts one pixel at the current raster position and advances it.
	function automatic yuv_sample_t predict_sample(input logic [23:0] px);
		int r;
		int g;
		int b;
		int w;
		int h;
		yuv_sample_t s;
		r = int'(px[7:0]);
		g = int'(px[15:8]);
		b = int'(px[23:16]);
		w = int'(width_reg);
		h = int'(height_reg);
		if (w < 2) w = 2;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		if (h < 1) h = 1;
		if (h > MAX_HEIGHT) h = MAX_HEIGHT;

		s.luma = scale_down(66 * r + 129 * g + 25 * b + 128, 16);
		s.kind = KIND_NONE;
		s.chroma = '0;
		s.frame_end = 1'b0;
		if (col_pos % 2 == 0) begin
			if (row_pos % 2 == 0) begin
				s.kind = KIND_U;
				s.chroma = scale_down(-38 * r - 74 * g + 112 * b + 128, 128);
			end else begin
				s.kind = KIND_V;
				s.chroma = scale_down(112 * r - 94 * g - 18 * b + 128, 128);
			end
		end

		// A shrunken width mid-frame ends the row at once; a shrunken height ends the frame at the row end.
		if (col_pos >= w - 1) begin
			col_pos = 0;
			if (row_pos >= h - 1) begin
				row_pos = 0;
				s.frame_end = 1'b1;
			end else begin
				row_pos++;
			end
		end else begin
			col_pos++;
		end
		return s;
	endfunction

	// Register writes, sample compares and pixel predictions, in that order.
	always @(posedge clk or negedge arst_n) begin
		yuv_sample_t exp_s;
		if (!arst_n) begin
			width_reg = FRAME_WIDTH_RST;
			height_reg = FRAME_HEIGHT_RST;
			col_pos = 0;
			row_pos = 0;
			fails = 0;
			frames_seen = 0;
			u_seen = 0;
			v_seen = 0;
			sample_index = 0;
			expected_samples.delete();
			mismatch_count <= 0;
			samples_pending <= 0;
			frame_ends <= 0;
			u_samples <= 0;
			v_samples <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FRAME_WIDTH: begin
						width_reg = cfg_data;
					end
					REG_FRAME_HEIGHT: begin
						height_reg = cfg_data;
					end
					default: begin
					end
				endcase
			end

			// The sample belongs to a pixel accepted at an earlier edge.
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_samples.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("tb: sample %0d arrived with no pixel outstanding: %h %h %b",
							sample_index, m_axis_tdata, m_axis_tuser, m_axis_tlast);
				end else begin
					exp_s = expected_samples.pop_front();
					if (m_axis_tdata[7:0] !== exp_s.luma || m_axis_tdata[15:8] !== exp_s.chroma ||
							m_axis_tuser !== exp_s.kind || m_axis_tlast !== exp_s.frame_end) begin
						fails++;
						if (fails <= 10)
							$display({"tb: sample %0d mismatch: expected luma %h chroma %h ",
								"kind %0d last %b, got luma %h chroma %h kind %0d last %b"},
								sample_index, exp_s.luma, exp_s.chroma, exp_s.kind,
								exp_s.frame_end, m_axis_tdata[7:0], m_axis_tdata[15:8],
								m_axis_tuser, m_axis_tlast);
					end
					if (exp_s.frame_end) frames_seen++;
					if (exp_s.kind == KIND_U) u_seen++;
					if (exp_s.kind == KIND_V) v_seen++;
				end
				sample_index++;
			end

			if (s_axis_tvalid && s_axis_tready)
				expected_samples.push_back(predict_sample(s_axis_tdata));

			mismatch_count <= fails;
			samples_pending <= expected_samples.size();
			frame_ends <= frames_seen;
			u_samples <= u_seen;
			v_samples <= v_seen;
		end
	end

endmodule

[verif/rgb24_to_yuv420_converter_unit_tb.sv]
// ----------------------------------------------------------------------------
// rgb24_to_yuv420_converter_unit_tb - stimulus and verdict for the converter
// Feeds directed and random pixel streams through a series of frame sizes,
// including out-of-range and mid-frame size changes, with bursty input and
// a stalling sample receiver. The scoreboard module does the checking.
// ----------------------------------------------------------------------------
module rgb24_to_yuv420_converter_unit_tb
	import rgb2yuv_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_PIXELS = 1200;
	localparam int IDLE_LIMIT    = 2000;
	localparam int DRAIN_CYCLES  = 4;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [23:0]          s_axis_tdata = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [15:0]          m_axis_tdata;
	logic [1:0]           m_axis_tuser;
	logic                 m_axis_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
	logic [CFG_W-1:0]     cfg_data = '0;

	int mismatch_count;
	int samples_pending;
	int frame_ends;
	int u_samples;
	int v_samples;

	int burst_left = 0;
	int idle_cycles = 0;
	int pixels_sent = 0;
	int size_settings = 0;

	// Receiver pacing state.
	int       rx_mode = 0;
	int       rx_phase_left = 0;
	int       rx_hold = 0;
	bit [7:0] rx_pattern = 8'hff;

	always #4 clk = ~clk;

	rgb24_to_yuv420_converter_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	yuv420_sample_checker scoreboard (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.m_axis_tlast    (m_axis_tlast),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatch_count  (mismatch_count),
		.samples_pending (samples_pending),
		.frame_ends      (frame_ends),
		.u_samples       (u_samples),
		.v_samples       (v_samples)
	);

	// The receiver switches between always ready, coin flips, a rotating
	// pattern and occasional long stalls.
	always @(posedge clk) begin
		if (rx_phase_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_phase_left = $urandom_range(16, 96);
			rx_pattern = 8'($urandom());
			rx_hold = 0;
		end
		rx_phase_left--;
		case (rx_mode)
			0: begin
				m_axis_tready <= 1'b1;
			end
			1: begin
				m_axis_tready <= 1'($urandom_range(0, 1));
			end
			2: begin
				rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
				m_axis_tready <= rx_pattern[0];
			end
			default: begin
				if (rx_hold > 0) begin
					rx_hold--;
					m_axis_tready <= 1'b0;
				end else if ($urandom_range(0, 7) == 0) begin
					rx_hold = $urandom_range(1, 12);
					m_axis_tready <= 1'b0;
				end else begin
					m_axis_tready <= 1'b1;
				end
			end
		endcase
	end

	// Watchdog: too many cycles without any accepted request ends the run.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: no request accepted for %0d cycles", IDLE_LIMIT);
			$display("tb: failure");
			$finish;
		end
	end

	// Offers one pixel, waits for its request to be taken, then paces the
	// next one by the burst and gap scheme.
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {b, g, r};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pixels_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
		end
	endtask

	// Waits until every sample has come back and the pipeline has settled.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (samples_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		wait_drained();
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		size_settings++;
	endtask

	function automatic logic [7:0] random_component();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom());
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] random_width();
		case ($urandom_range(0, 9))
			0: return CFG_W'($urandom());
			1: return CFG_W'($urandom_range(0, 1));
			2: return ($urandom_range(0, 1) == 0) ? CFG_W'(4096) : CFG_W'(4097);
			default: return CFG_W'($urandom_range(2, 10));
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] random_height();
		case ($urandom_range(0, 9))
			0: return CFG_W'($urandom());
			1: return CFG_W'(0);
			2: return ($urandom_range(0, 1) == 0) ? CFG_W'(4096) : CFG_W'(8191);
			default: return CFG_W'($urandom_range(1, 6));
		endcase
	endfunction

	// Main sequence.
	initial begin
		int rand_pixels;
		int n;
		rand_pixels = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Default size: component extremes at the start of a row.
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hff, 8'hff, 8'hff);
		send_pixel(8'hff, 8'h00, 8'h00);
		send_pixel(8'h00, 8'hff, 8'h00);
		send_pixel(8'h00, 8'h00, 8'hff);

		// Smallest frame, then widths and heights below the legal range.
		set_size(13'd2, 13'd1);
		send_pixel(8'hff, 8'h00, 8'hff);
		send_pixel(8'h00, 8'hff, 8'hff);
		set_size(13'd0, 13'd2);
		send_pixel(8'hff, 8'hff, 8'h00);
		send_pixel(8'h80, 8'h7f, 8'h01);
		send_pixel(8'hff, 8'h00, 8'h00);
		send_pixel(8'h00, 8'h00, 8'hff);
		set_size(13'd1, 13'd0);
		send_pixel(8'h01, 8'hfe, 8'h55);
		send_pixel(8'haa, 8'h55, 8'hfe);

		// Sizes above the limit act as the limit.
		set_size(13'd8191, 13'd8191);
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hff, 8'hff, 8'hff);
		send_pixel(8'h12, 8'h34, 8'h56);

		// Width shrunk below the current column ends the row at once.
		wait_drained();
		write_reg(REG_FRAME_WIDTH, 13'd2);
		write_reg(2'd2, CFG_W'($urandom()));
		write_reg(2'd3, CFG_W'($urandom()));
		size_settings++;
		send_pixel(8'hff, 8'h00, 8'h00);
		send_pixel(8'h00, 8'hff, 8'h00);

		// Height shrunk below the current row ends the frame at the row end.
		set_size(13'd2, 13'd50);
		repeat (4) send_pixel(random_component(), random_component(), random_component());
		wait_drained();
		write_reg(REG_FRAME_HEIGHT, 13'd2);
		size_settings++;
		repeat (2) send_pixel(random_component(), random_component(), random_component());

		// Random phases, some changing only one dimension mid-frame.
		while (rand_pixels < RANDOM_PIXELS) begin
			wait_drained();
			case ($urandom_range(0, 4))
				0: begin
					write_reg(REG_FRAME_WIDTH, random_width());
				end
				1: begin
					write_reg(REG_FRAME_HEIGHT, random_height());
				end
				default: begin
					write_reg(REG_FRAME_WIDTH, random_width());
					write_reg(REG_FRAME_HEIGHT, random_height());
				end
			endcase
			size_settings++;
			n = $urandom_range(10, 90);
			repeat (n) send_pixel(random_component(), random_component(), random_component());
			rand_pixels += n;
		end

		wait_drained();
		repeat (8) @(posedge clk);
		$display("tb: %0d pixels over %0d frame size settings, %0d frame ends",
			pixels_sent, size_settings, frame_ends);
		$display("tb: %0d U and %0d V samples, %0d mismatches",
			u_samples, v_samples, mismatch_count);
		if (mismatch_count == 0 && samples_pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[sim.f]
sv/rgb2yuv_pkg.sv
sv/rgb24_to_yuv420_converter_unit.sv
verif/yuv420_sample_checker.sv
verif/rgb24_to_yuv420_converter_unit_tb.sv
